@@ src/tlscv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLS ClientHello version classifier package
// Shared types, protocol constants and verdict codes.
// ----------------------------------------------------------------------------
package tlscv_pkg;

    // Protocol constants.
    localparam logic [7:0]  REC_HANDSHAKE          = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO        = 8'h01;
    localparam logic [15:0] EXT_SUPPORTED_VERSIONS = 16'd43;
    localparam logic [7:0]  VER_MAJOR              = 8'h03;
    localparam logic [7:0]  VER_MINOR_13           = 8'h04;
    localparam logic [15:0] RANDOM_BYTES           = 16'd34;
    localparam logic [15:0] HEADER_BYTES           = 16'd5;

    // Configuration.
    localparam int unsigned   LIMIT_W          = 16;
    localparam logic [15:0]   PEEK_LIMIT_RESET = 16'd1024;

    // Verdict codes.
    typedef enum logic [1:0] {
        VERDICT_INCOMPLETE = 2'd0,
        VERDICT_TLS13      = 2'd1,
        VERDICT_NO_TLS13   = 2'd2
    } t_verdict;

    // Parse phases, one-hot.
    typedef enum logic [13:0] {
        PH_REC   = 14'h0001,
        PH_HS    = 14'h0002,
        PH_RAND  = 14'h0004,
        PH_FLEN  = 14'h0008,
        PH_FLEN2 = 14'h0010,
        PH_FBODY = 14'h0020,
        PH_XLEN  = 14'h0040,
        PH_XLEN2 = 14'h0080,
        PH_XHDR  = 14'h0100,
        PH_XSKIP = 14'h0200,
        PH_XVLEN = 14'h0400,
        PH_XVER  = 14'h0800,
        PH_XDONE = 14'h1000,
        PH_XOVER = 14'h2000
    } t_phase;

endpackage
`default_nettype wire

@@ src/tls_client_hello_version_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLS ClientHello version classifier
// Parses the first TLS record of a peeked buffer, one byte per transfer, and
// gives one verdict per buffer: incomplete, TLS 1.3 offered, or no TLS 1.3.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                          Meaning
//  --------  ---------  -------------------------------  ---------------------
//  s_axis    in         tvalid tready tdata[7:0] tlast   one buffer byte,
//                                                        tlast = last byte
//  m_axis    out        tvalid tready tdata[7:0]         verdict, 0..2
//  cfg       in         i_cfg_we i_cfg_wdata[15:0]       peek limit register
//
//  Every byte is handled in the cycle it is accepted: the parse state and the
//  verdict register are updated at the same clock edge, so one byte per cycle
//  is sustained. Input stalls only while a verdict waits in the output
//  register and m_axis_tready is low, for as long as the sink holds it low.
//  Reset (synchronous, active low) restarts the parser at the record header
//  and sets the peek limit to 1024. A verdict appears in the cycle after the
//  byte that settles it.
//
module tls_client_hello_version_classifier #(
    parameter logic [tlscv_pkg::LIMIT_W-1:0] PEEK_LIMIT_RESET = tlscv_pkg::PEEK_LIMIT_RESET
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Byte stream in.
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  wire logic                          s_axis_tlast,   // last_byte
    // Verdict out.
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [1:0] verdict, [7:2] zero
    // Configuration.
    input  wire logic                          i_cfg_we,
    input  wire logic [tlscv_pkg::LIMIT_W-1:0] i_cfg_wdata
);

    // Configuration register.
    logic [tlscv_pkg::LIMIT_W-1:0] r_limit;

    // Parse state.
    logic [15:0]       r_cnt,   n_cnt;    // bytes stored so far
    logic [15:0]       r_rl,    n_rl;     // record bytes still to come
    tlscv_pkg::t_phase r_phase, n_phase;
    logic [1:0]        r_fi,    n_fi;     // byte or field number within a phase
    logic [15:0]       r_fr,    n_fr;     // bytes left in random or a field
    logic [15:0]       r_xr,    n_xr;     // bytes left in the extension block
    logic [15:0]       r_kind,  n_kind;   // current extension type
    logic [15:0]       r_er,    n_er;     // bytes left in the current extension
    logic [7:0]        r_vlr,   n_vlr;    // version list bytes left to examine
    logic [7:0]        r_pair,  n_pair;   // handshake type, then version high byte
    logic [7:0]        r_first, n_first;  // record content type
    logic              r_given, n_given;  // verdict given for this buffer

    // Output register.
    logic                r_m_valid;
    tlscv_pkg::t_verdict r_verdict;

    logic                s_accept;
    logic                v_ok;
    tlscv_pkg::t_verdict v_val;
    logic [7:0]          b;
    logic [15:0]         room;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_verdict};

    // Next state for one accepted byte.
    always_comb begin
        n_cnt   = r_cnt;
        n_rl    = r_rl;
        n_phase = r_phase;
        n_fi    = r_fi;
        n_fr    = r_fr;
        n_xr    = r_xr;
        n_kind  = r_kind;
        n_er    = r_er;
        n_vlr   = r_vlr;
        n_pair  = r_pair;
        n_first = r_first;
        v_ok    = 1'b0;
        v_val   = tlscv_pkg::VERDICT_INCOMPLETE;
        room    = r_er - 16'd1;

        if (!r_given && (r_cnt < r_limit)) begin
            n_cnt = r_cnt + 16'd1;
            if (r_cnt < tlscv_pkg::HEADER_BYTES) begin
                // Record header: content type, version, length.
                if (r_cnt == 16'd0) begin
                    n_first = b;
                end else if (r_cnt == 16'd3) begin
                    n_rl = {b, 8'h00};
                end else if (r_cnt == 16'd4) begin
                    n_rl = {r_rl[15:8], b};
                    if (r_first != tlscv_pkg::REC_HANDSHAKE) begin
                        v_ok  = 1'b1;
                        v_val = tlscv_pkg::VERDICT_NO_TLS13;
                    end else begin
                        n_phase = tlscv_pkg::PH_HS;
                        n_fi    = 2'd0;
                    end
                end
            end else if (r_rl != 16'd0) begin
                n_rl = r_rl - 16'd1;
                unique case (r_phase)
                    tlscv_pkg::PH_HS: begin
                        if (r_fi == 2'd0) n_pair = b;
                        if (r_fi != 2'd3) begin
                            n_fi = r_fi + 2'd1;
                        end else if (r_pair != tlscv_pkg::HS_CLIENT_HELLO) begin
                            v_ok  = 1'b1;
                            v_val = tlscv_pkg::VERDICT_NO_TLS13;
                        end else begin
                            n_phase = tlscv_pkg::PH_RAND;
                            n_fr    = tlscv_pkg::RANDOM_BYTES;
                            n_fi    = 2'd0;
                        end
                    end
                    tlscv_pkg::PH_RAND: begin
                        n_fr = r_fr - 16'd1;
                        if (n_fr == 16'd0) begin
                            n_phase = tlscv_pkg::PH_FLEN;
                            n_fi    = 2'd0;
                        end
                    end
                    tlscv_pkg::PH_FLEN, tlscv_pkg::PH_FLEN2, tlscv_pkg::PH_FBODY: begin
                        // Session id (1-byte length), cipher suites (2-byte length)
                        // and compression methods (1-byte length).
                        if (r_phase == tlscv_pkg::PH_FLEN && r_fi == 2'd1) begin
                            n_fr    = {b, 8'h00};
                            n_phase = tlscv_pkg::PH_FLEN2;
                        end else begin
                            if (r_phase == tlscv_pkg::PH_FLEN) n_fr = {8'h00, b};
                            else if (r_phase == tlscv_pkg::PH_FLEN2) n_fr = {r_fr[15:8], b};
                            else n_fr = r_fr - 16'd1;
                            if (n_fr != 16'd0) begin
                                n_phase = tlscv_pkg::PH_FBODY;
                            end else if (r_fi >= 2'd2) begin
                                n_phase = tlscv_pkg::PH_XLEN;
                                n_fi    = 2'd0;
                            end else begin
                                n_fi    = r_fi + 2'd1;
                                n_phase = tlscv_pkg::PH_FLEN;
                            end
                        end
                    end
                    tlscv_pkg::PH_XLEN: begin
                        n_xr    = {b, 8'h00};
                        n_phase = tlscv_pkg::PH_XLEN2;
                    end
                    tlscv_pkg::PH_XLEN2: begin
                        n_xr    = {r_xr[15:8], b};
                        n_fi    = 2'd0;
                        n_phase = (n_xr == 16'd0) ? tlscv_pkg::PH_XDONE : tlscv_pkg::PH_XHDR;
                    end
                    tlscv_pkg::PH_XHDR: begin
                        n_xr = r_xr - 16'd1;
                        unique case (r_fi)
                            2'd0:    n_kind = {b, 8'h00};
                            2'd1:    n_kind = {r_kind[15:8], b};
                            2'd2:    n_er   = {b, 8'h00};
                            default: n_er   = {r_er[15:8], b};
                        endcase
                        if (r_fi != 2'd3) begin
                            n_fi = r_fi + 2'd1;
                            if (n_xr == 16'd0) n_phase = tlscv_pkg::PH_XDONE;
                        end else begin
                            n_fi = 2'd0;
                            if (n_er > n_xr) begin
                                n_phase = tlscv_pkg::PH_XOVER;
                            end else if (n_kind == tlscv_pkg::EXT_SUPPORTED_VERSIONS) begin
                                if (n_er == 16'd0) begin
                                    v_ok  = 1'b1;
                                    v_val = tlscv_pkg::VERDICT_NO_TLS13;
                                end else begin
                                    n_phase = tlscv_pkg::PH_XVLEN;
                                end
                            end else if (n_er == 16'd0) begin
                                n_phase = (n_xr == 16'd0) ? tlscv_pkg::PH_XDONE
                                                          : tlscv_pkg::PH_XHDR;
                            end else begin
                                n_phase = tlscv_pkg::PH_XSKIP;
                            end
                        end
                    end
                    tlscv_pkg::PH_XSKIP: begin
                        n_xr = r_xr - 16'd1;
                        n_er = r_er - 16'd1;
                        if (n_er == 16'd0) begin
                            n_fi    = 2'd0;
                            n_phase = (n_xr == 16'd0) ? tlscv_pkg::PH_XDONE
                                                      : tlscv_pkg::PH_XHDR;
                        end
                    end
                    tlscv_pkg::PH_XVLEN: begin
                        // The list length is clipped to the room left in the extension.
                        n_vlr = ({8'h00, b} < room) ? b : room[7:0];
                        n_fi  = 2'd0;
                        n_xr  = r_xr - 16'd1;
                        n_er  = room;
                        if (n_er == 16'd0) begin
                            v_ok  = 1'b1;
                            v_val = tlscv_pkg::VERDICT_NO_TLS13;
                        end else begin
                            n_phase = tlscv_pkg::PH_XVER;
                        end
                    end
                    tlscv_pkg::PH_XVER: begin
                        // Bit 0 of the field index is the pair position, bit 1 is set
                        // once version 3.4 has been seen.
                        if (!r_fi[0]) begin
                            if (r_vlr >= 8'd2) begin
                                n_pair = b;
                                n_vlr  = r_vlr - 8'd1;
                                n_fi   = {r_fi[1], 1'b1};
                            end else begin
                                n_vlr = 8'd0;
                            end
                        end else begin
                            n_fi  = {r_fi[1] || (r_pair == tlscv_pkg::VER_MAJOR &&
                                                 b == tlscv_pkg::VER_MINOR_13), 1'b0};
                            n_vlr = r_vlr - 8'd1;
                        end
                        n_xr = r_xr - 16'd1;
                        n_er = r_er - 16'd1;
                        if (n_er == 16'd0) begin
                            v_ok  = 1'b1;
                            v_val = n_fi[1] ? tlscv_pkg::VERDICT_TLS13
                                            : tlscv_pkg::VERDICT_NO_TLS13;
                        end
                    end
                    default: begin
                        // Record header, extension block done, or overflow: no work.
                    end
                endcase
            end

            // Record complete.
            if (!v_ok && n_cnt >= tlscv_pkg::HEADER_BYTES && n_rl == 16'd0) begin
                v_ok  = 1'b1;
                v_val = (n_phase == tlscv_pkg::PH_XLEN || n_phase == tlscv_pkg::PH_XDONE)
                      ? tlscv_pkg::VERDICT_NO_TLS13 : tlscv_pkg::VERDICT_TLS13;
            end
            // Buffer full.
            if (!v_ok && n_cnt == r_limit) begin
                v_ok  = 1'b1;
                v_val = (n_cnt < tlscv_pkg::HEADER_BYTES) ? tlscv_pkg::VERDICT_INCOMPLETE
                                                          : tlscv_pkg::VERDICT_TLS13;
            end
        end

        // Last byte of the buffer with no verdict yet.
        if (!v_ok && !r_given && s_axis_tlast) begin
            v_ok  = 1'b1;
            v_val = (n_cnt < tlscv_pkg::HEADER_BYTES || n_cnt < r_limit)
                  ? tlscv_pkg::VERDICT_INCOMPLETE : tlscv_pkg::VERDICT_TLS13;
        end

        n_given = r_given || v_ok;

        // The next buffer starts from scratch.
        if (s_axis_tlast) begin
            n_cnt   = 16'd0;
            n_rl    = 16'd0;
            n_phase = tlscv_pkg::PH_REC;
            n_fi    = 2'd0;
            n_fr    = 16'd0;
            n_xr    = 16'd0;
            n_kind  = 16'd0;
            n_er    = 16'd0;
            n_vlr   = 8'd0;
            n_pair  = 8'd0;
            n_first = 8'd0;
            n_given = 1'b0;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= PEEK_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // Parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 16'd0;
            r_rl    <= 16'd0;
            r_phase <= tlscv_pkg::PH_REC;
            r_fi    <= 2'd0;
            r_fr    <= 16'd0;
            r_xr    <= 16'd0;
            r_kind  <= 16'd0;
            r_er    <= 16'd0;
            r_vlr   <= 8'd0;
            r_pair  <= 8'd0;
            r_first <= 8'd0;
            r_given <= 1'b0;
        end else if (s_accept) begin
            r_cnt   <= n_cnt;
            r_rl    <= n_rl;
            r_phase <= n_phase;
            r_fi    <= n_fi;
            r_fr    <= n_fr;
            r_xr    <= n_xr;
            r_kind  <= n_kind;
            r_er    <= n_er;
            r_vlr   <= n_vlr;
            r_pair  <= n_pair;
            r_first <= n_first;
            r_given <= n_given;
        end
    end

    // Output register: a verdict waits here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept && v_ok) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && v_ok) begin
            r_verdict <= v_val;
        end
    end

endmodule
`default_nettype wire

@@ src/tlscv_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// TLS ClientHello version classifier checker
// Port-level assertions on the verdict stream, bound to the top level.
// ----------------------------------------------------------------------------
module tlscv_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // A stalled verdict stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed or dropped while stalled");

    // Only the three defined verdicts appear, with zero padding.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'd0 && m_axis_tdata[1:0] != 2'd3)
        else $error("undefined verdict code");

    // An empty output register never blocks the byte stream.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // Reset leaves no verdict behind.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid after reset");

    // A verdict appears only in the cycle after a byte transfer.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("verdict without a byte transfer");

endmodule

bind tls_client_hello_version_classifier tlscv_checker u_tlscv_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// TLS ClientHello version classifier testbench
// Drives peeked TLS buffers into the classifier one byte per transfer, under
// random idling on both streams and several peek limits. A byte-level
// predictor works out the verdict that each buffer must give, and every
// verdict transfer is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF      = 5;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned MAX_GAP       = 18;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int          MIN_BUFFERS   = 4;

    // ------------------------------------------------------------------------
    // Verdict predictor and checker. It follows the classifier byte by byte,
    // keeps the verdicts still owed by the block, and compares each verdict
    // transfer with the oldest one.
    // ------------------------------------------------------------------------
    class client_hello_checker;
        logic [15:0]         peek_limit;
        logic [16:0]         byte_cnt;
        logic [15:0]         rec_left;
        tlscv_pkg::t_phase   phase;
        logic [1:0]          step_idx;
        logic [15:0]         field_left;
        logic [15:0]         ext_block_left;
        logic [15:0]         ext_kind;
        logic [15:0]         ext_left;
        logic [7:0]          ver_left;
        logic [7:0]          held_byte;
        logic [7:0]          content_type;
        bit                  decided;

        tlscv_pkg::t_verdict pending_verdicts[$];
        int                  verdicts_owed;
        int                  mismatches;
        int                  kind_seen[3];

        function new();
            peek_limit    = tlscv_pkg::PEEK_LIMIT_RESET;
            verdicts_owed = 0;
            mismatches    = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            byte_cnt       = '0;
            rec_left       = '0;
            phase          = tlscv_pkg::PH_REC;
            step_idx       = '0;
            field_left     = '0;
            ext_block_left = '0;
            ext_kind       = '0;
            ext_left       = '0;
            ver_left       = '0;
            held_byte      = '0;
            content_type   = '0;
            decided        = 1'b0;
        endfunction

        function void set_limit(logic [15:0] value);
            peek_limit = value;
        endfunction

        // Session id, cipher suites and compression methods come in turn,
        // and the extension block length follows the third.
        function void advance_field();
            if (step_idx >= 2) begin
                phase    = tlscv_pkg::PH_XLEN;
                step_idx = '0;
            end else begin
                step_idx = step_idx + 2'd1;
                phase    = tlscv_pkg::PH_FLEN;
            end
        endfunction

        function void body_or_advance();
            if (field_left == 0) advance_field();
            else phase = tlscv_pkg::PH_FBODY;
        endfunction

        function void advance_extension();
            step_idx = '0;
            phase    = (ext_block_left == 0) ? tlscv_pkg::PH_XDONE : tlscv_pkg::PH_XHDR;
        endfunction

        function void consume_ext_byte();
            ext_block_left = ext_block_left - 16'd1;
            ext_left       = ext_left - 16'd1;
        endfunction

        // One byte of the record body. Returns 1 when it settles the verdict.
        function bit parse_body(logic [7:0] b, output tlscv_pkg::t_verdict v);
            logic [15:0] room;
            v = tlscv_pkg::VERDICT_INCOMPLETE;
            case (phase)
                tlscv_pkg::PH_HS: begin
                    if (step_idx == 0) held_byte = b;
                    if (step_idx < 3) begin
                        step_idx = step_idx + 2'd1;
                    end else begin
                        if (held_byte != tlscv_pkg::HS_CLIENT_HELLO) begin
                            v = tlscv_pkg::VERDICT_NO_TLS13;
                            return 1'b1;
                        end
                        phase      = tlscv_pkg::PH_RAND;
                        field_left = tlscv_pkg::RANDOM_BYTES;
                        step_idx   = '0;
                    end
                end
                tlscv_pkg::PH_RAND: begin
                    field_left = field_left - 16'd1;
                    if (field_left == 0) begin
                        phase    = tlscv_pkg::PH_FLEN;
                        step_idx = '0;
                    end
                end
                tlscv_pkg::PH_FLEN: begin
                    if (step_idx == 1) begin
                        field_left = {b, 8'h00};
                        phase      = tlscv_pkg::PH_FLEN2;
                    end else begin
                        field_left = {8'h00, b};
                        body_or_advance();
                    end
                end
                tlscv_pkg::PH_FLEN2: begin
                    field_left[7:0] = b;
                    body_or_advance();
                end
                tlscv_pkg::PH_FBODY: begin
                    field_left = field_left - 16'd1;
                    if (field_left == 0) advance_field();
                end
                tlscv_pkg::PH_XLEN: begin
                    ext_block_left = {b, 8'h00};
                    phase          = tlscv_pkg::PH_XLEN2;
                end
                tlscv_pkg::PH_XLEN2: begin
                    ext_block_left[7:0] = b;
                    advance_extension();
                end
                tlscv_pkg::PH_XHDR: begin
                    ext_block_left = ext_block_left - 16'd1;
                    case (step_idx)
                        2'd0: ext_kind      = {b, 8'h00};
                        2'd1: ext_kind[7:0] = b;
                        2'd2: ext_left      = {b, 8'h00};
                        default: ext_left[7:0] = b;
                    endcase
                    if (step_idx < 3) begin
                        step_idx = step_idx + 2'd1;
                        // A block that ends inside an extension header is done.
                        if (ext_block_left == 0) phase = tlscv_pkg::PH_XDONE;
                    end else begin
                        step_idx = '0;
                        if (ext_left > ext_block_left) begin
                            phase = tlscv_pkg::PH_XOVER;
                        end else if (ext_kind == tlscv_pkg::EXT_SUPPORTED_VERSIONS) begin
                            if (ext_left == 0) begin
                                v = tlscv_pkg::VERDICT_NO_TLS13;
                                return 1'b1;
                            end
                            phase = tlscv_pkg::PH_XVLEN;
                        end else if (ext_left == 0) begin
                            advance_extension();
                        end else begin
                            phase = tlscv_pkg::PH_XSKIP;
                        end
                    end
                end
                tlscv_pkg::PH_XSKIP: begin
                    consume_ext_byte();
                    if (ext_left == 0) advance_extension();
                end
                tlscv_pkg::PH_XVLEN: begin
                    // The list length byte is trusted only as far as the
                    // extension leaves room for it.
                    room     = ext_left - 16'd1;
                    ver_left = ({8'h00, b} < room) ? b : room[7:0];
                    step_idx = '0;
                    consume_ext_byte();
                    if (ext_left == 0) begin
                        v = tlscv_pkg::VERDICT_NO_TLS13;
                        return 1'b1;
                    end
                    phase = tlscv_pkg::PH_XVER;
                end
                tlscv_pkg::PH_XVER: begin
                    // step_idx[0] is the position within a version pair and
                    // step_idx[1] remembers that 3.4 was listed.
                    if (!step_idx[0]) begin
                        if (ver_left >= 2) begin
                            held_byte   = b;
                            ver_left    = ver_left - 8'd1;
                            step_idx[0] = 1'b1;
                        end else begin
                            ver_left = '0;
                        end
                    end else begin
                        if (held_byte == tlscv_pkg::VER_MAJOR &&
                            b == tlscv_pkg::VER_MINOR_13) step_idx[1] = 1'b1;
                        step_idx[0] = 1'b0;
                        ver_left    = ver_left - 8'd1;
                    end
                    consume_ext_byte();
                    if (ext_left == 0) begin
                        v = step_idx[1] ? tlscv_pkg::VERDICT_TLS13
                                        : tlscv_pkg::VERDICT_NO_TLS13;
                        return 1'b1;
                    end
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        // Verdict once no further byte can count.
        function tlscv_pkg::t_verdict settle(bit rec_done, bit room_left);
            if (byte_cnt < 5) return tlscv_pkg::VERDICT_INCOMPLETE;
            if (rec_done && (phase == tlscv_pkg::PH_XLEN || phase == tlscv_pkg::PH_XDONE))
                return tlscv_pkg::VERDICT_NO_TLS13;
            return (!rec_done && room_left) ? tlscv_pkg::VERDICT_INCOMPLETE
                                            : tlscv_pkg::VERDICT_TLS13;
        endfunction

        // Notes one accepted input byte. Returns 1 when the byte was parsed
        // rather than ignored.
        function bit take_byte(logic [7:0] b, bit last);
            bit                  settled;
            bit                  parsed;
            tlscv_pkg::t_verdict v;
            settled = 1'b0;
            parsed  = 1'b0;
            v       = tlscv_pkg::VERDICT_INCOMPLETE;
            if (!decided && byte_cnt < {1'b0, peek_limit}) begin
                parsed   = 1'b1;
                byte_cnt = byte_cnt + 17'd1;
                if (byte_cnt <= 5) begin
                    if (byte_cnt == 1) begin
                        content_type = b;
                    end else if (byte_cnt == 4) begin
                        rec_left = {b, 8'h00};
                    end else if (byte_cnt == 5) begin
                        rec_left[7:0] = b;
                        if (content_type != tlscv_pkg::REC_HANDSHAKE) begin
                            settled = 1'b1;
                            v       = tlscv_pkg::VERDICT_NO_TLS13;
                        end else begin
                            phase    = tlscv_pkg::PH_HS;
                            step_idx = '0;
                        end
                    end
                end else if (rec_left != 0) begin
                    settled  = parse_body(b, v);
                    rec_left = rec_left - 16'd1;
                end
                if (!settled && byte_cnt >= 5 && rec_left == 0) begin
                    settled = 1'b1;
                    v       = settle(1'b1, 1'b0);
                end
                if (!settled && byte_cnt == {1'b0, peek_limit}) begin
                    settled = 1'b1;
                    v       = settle(1'b0, 1'b0);
                end
            end
            if (!settled && !decided && last) begin
                settled = 1'b1;
                v       = settle(1'b0, byte_cnt < {1'b0, peek_limit});
            end
            if (settled) begin
                decided = 1'b1;
                pending_verdicts.push_back(v);
                verdicts_owed++;
            end
            if (last) clear_buffer();
            return parsed;
        endfunction

        function void check_verdict(logic [7:0] got);
            tlscv_pkg::t_verdict want;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] verdict transfer 0x%02h arrived with none owed", $realtime, got);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got[1:0] <= 2'd2) kind_seen[got[1:0]]++;
            if (got !== {6'b0, want}) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] verdict: expected %s (0x%02h), got 0x%02h", $realtime,
                             want.name(), {6'b0, want}, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] data_byte
    logic        s_axis_tlast;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [1:0] verdict, [7:2] zero
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    tls_client_hello_version_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    client_hello_checker checker_h = new();

    int unsigned cycles        = 0;
    int          bytes_sent    = 0;
    int          bytes_parsed  = 0;
    int          buffers_sent  = 0;
    bit          source_steady = 1'b0;   // no gaps between bytes of this buffer
    bit          sink_steady   = 1'b0;   // no stalls on the verdict side

    // ------------------------------------------------------------------------
    // Clock, and a watchdog that ends a run which has hung.
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles with %0d verdicts owed",
                     cycles, checker_h.pending_verdicts.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Every verdict transfer is checked at the rising edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) checker_h.check_verdict(m_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // Verdict side. Each transfer is preceded by a random stall: m_axis_tready
    // stays low until a verdict is offered and for a drawn number of cycles
    // after that. Now and then a stretch runs with m_axis_tready held high.
    // ------------------------------------------------------------------------
    initial begin : verdict_sink
        int stall;
        forever begin
            if ($urandom_range(0, 7) == 0) sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge i_clk);
            m_axis_tready <= (stall == 0);
            if (stall > 0) begin
                do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
                repeat (stall) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            do @(posedge i_clk); while (!(m_axis_tvalid === 1'b1 && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------------
    // Byte side. Inputs change at the falling edge only. After a transfer
    // the next byte follows at once, so s_axis_tvalid stays high through a
    // buffer sent without gaps and is lowered only for a drawn gap or a drain.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input bit last);
        int gap;
        gap = source_steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (checker_h.take_byte(value, last)) bytes_parsed++;
    endtask

    task automatic send_buffer(input logic [7:0] octets[$]);
        source_steady = ($urandom_range(0, 4) == 0);
        foreach (octets[i]) send_byte(octets[i], i == octets.size() - 1);
        buffers_sent++;
    endtask

    // The source goes quiet until every owed verdict has been taken, and then
    // a few cycles more so that nothing is still in flight inside the block.
    task automatic drain_verdicts();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (checker_h.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_peek_limit(input logic [15:0] value);
        drain_verdicts();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        checker_h.set_limit(value);
    endtask

    // ------------------------------------------------------------------------
    // Buffer generators.
    // ------------------------------------------------------------------------
    function automatic void push_random(ref logic [7:0] q[$], input int count);
        repeat (count) q.push_back(8'($urandom));
    endfunction

    // Random bytes, half of them starting like a handshake record.
    function automatic void build_noise(output logic [7:0] octets[$]);
        octets = {};
        push_random(octets, $urandom_range(1, 20));
        if ($urandom_range(0, 1) == 0) octets[0] = tlscv_pkg::REC_HANDSHAKE;
    endfunction

    // One supported versions extension, mostly well formed. The list length
    // byte, the extension length and the content are sometimes off.
    function automatic void build_versions_ext(ref logic [7:0] ext[$]);
        logic [7:0]  body[$];
        int          pairs;
        int          vlist_bytes;
        int          ext_len;
        pairs = $urandom_range(0, 4);
        body  = {};
        repeat (pairs) begin
            case ($urandom_range(0, 3))
                0: body = {body, tlscv_pkg::VER_MAJOR, tlscv_pkg::VER_MINOR_13};
                1: body = {body, tlscv_pkg::VER_MAJOR, 8'h03};
                2: body = {body, 8'h7f, 8'h1c};
                default: push_random(body, 2);
            endcase
        end
        vlist_bytes = 2 * pairs;
        case ($urandom_range(0, 7))
            0: vlist_bytes = $urandom_range(0, 255);
            1: vlist_bytes = vlist_bytes + 1;
            default: ;
        endcase
        body.push_front(8'(vlist_bytes));
        if ($urandom_range(0, 7) == 0) push_random(body, 1);
        ext_len = body.size();
        case ($urandom_range(0, 9))
            0: begin
                body    = {};
                ext_len = 0;
            end
            1: ext_len = $urandom_range(0, body.size() + 4);
            default: ;
        endcase
        ext = {ext, tlscv_pkg::EXT_SUPPORTED_VERSIONS[15:8],
               tlscv_pkg::EXT_SUPPORTED_VERSIONS[7:0], 8'(ext_len >> 8), 8'(ext_len)};
        ext = {ext, body};
    endfunction

    // A ClientHello record with random content. Most are well formed; some
    // carry a wrong record length, a wrong extension block length, a byte
    // that is replaced, trailing bytes after the record, or are cut short.
    function automatic void build_hello(output logic [7:0] octets[$]);
        logic [7:0] body[$];
        logic [7:0] ext[$];
        int         n;
        int         ext_total;
        int         rec_len;
        body = {};
        ext  = {};
        body.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                    : tlscv_pkg::HS_CLIENT_HELLO);
        push_random(body, 3);
        body = {body, tlscv_pkg::VER_MAJOR, 8'h03};
        push_random(body, 32);
        n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(0, 8);
        body.push_back(8'(n));
        push_random(body, n);
        n = 2 * $urandom_range(0, 4) + (($urandom_range(0, 7) == 0) ? 1 : 0);
        body = {body, 8'(n >> 8), 8'(n)};
        push_random(body, n);
        n = $urandom_range(0, 2);
        body.push_back(8'(n));
        push_random(body, n);
        if ($urandom_range(0, 7) != 0) begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1) == 0) begin
                    build_versions_ext(ext);
                end else begin
                    n = $urandom_range(0, 6);
                    push_random(ext, 2);
                    ext = {ext, 8'h00, 8'(n)};
                    push_random(ext, n);
                end
            end
            ext_total = ext.size();
            if ($urandom_range(0, 9) == 0) ext_total = $urandom_range(0, ext.size() + 6);
            body = {body, 8'(ext_total >> 8), 8'(ext_total)};
            body = {body, ext};
        end
        rec_len = body.size();
        if ($urandom_range(0, 7) == 0) rec_len = $urandom_range(0, body.size() + 8);
        octets = {tlscv_pkg::REC_HANDSHAKE, tlscv_pkg::VER_MAJOR, 8'h01,
                  8'(rec_len >> 8), 8'(rec_len)};
        octets = {octets, body};
        if ($urandom_range(0, 9) == 0) octets[$urandom_range(0, octets.size() - 1)] = 8'($urandom);
        if ($urandom_range(0, 3) == 0) push_random(octets, $urandom_range(1, 3));
        if ($urandom_range(0, 7) == 0) octets = octets[0:$urandom_range(0, octets.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0]  octets[$];
        logic [15:0] limits[NUM_PHASES];
        int          quota[NUM_PHASES];
        int          start_sent;
        int          start_owed;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed buffers under the reset peek limit.
        // A buffer that ends before the record header is complete.
        send_buffer({tlscv_pkg::REC_HANDSHAKE, tlscv_pkg::VER_MAJOR, 8'h01});
        // An application data record is rejected at its fifth byte.
        send_buffer({8'h17, tlscv_pkg::VER_MAJOR, 8'h03, 8'h00, 8'h10});
        // A handshake record of length zero completes at once.
        send_buffer({tlscv_pkg::REC_HANDSHAKE, tlscv_pkg::VER_MAJOR, 8'h01, 8'h00, 8'h00});
        // A handshake that is not a ClientHello, then a byte that is ignored.
        send_buffer({tlscv_pkg::REC_HANDSHAKE, tlscv_pkg::VER_MAJOR, 8'h01, 8'h00, 8'h04,
                     8'h02, 8'h00, 8'h00, 8'h00, 8'hff});
        // Extreme byte values in a short buffer.
        send_buffer({8'h00, 8'hff});

        // Random buffers over several peek limits: the reset value, the
        // smallest one, the largest, one that cuts most records short, one
        // of moderate size, and the reset value written back.
        limits = '{tlscv_pkg::PEEK_LIMIT_RESET, 16'd5, 16'hffff,
                   16'($urandom_range(45, 100)), 16'($urandom_range(101, 700)),
                   tlscv_pkg::PEEK_LIMIT_RESET};
        quota  = '{150, 40, 150, 100, 100, 100};
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) set_peek_limit(limits[p]);
            start_sent = bytes_sent;
            start_owed = checker_h.verdicts_owed;
            while (bytes_sent - start_sent < quota[p] ||
                   checker_h.verdicts_owed - start_owed < MIN_BUFFERS) begin
                if ($urandom_range(0, 4) == 0) build_noise(octets);
                else build_hello(octets);
                send_buffer(octets);
            end
        end

        drain_verdicts();

        $display("Sent %0d buffers, %0d bytes of which %0d were parsed, under peek limits",
                 buffers_sent, bytes_sent, bytes_parsed);
        $display("  5, 65535, %0d, %0d and 1024; verdicts incomplete %0d, TLS 1.3 %0d, no TLS 1.3 %0d",
                 limits[3], limits[4], checker_h.kind_seen[tlscv_pkg::VERDICT_INCOMPLETE],
                 checker_h.kind_seen[tlscv_pkg::VERDICT_TLS13],
                 checker_h.kind_seen[tlscv_pkg::VERDICT_NO_TLS13]);
        if (checker_h.pending_verdicts.size() != 0)
            $display("%0d verdicts were never delivered", checker_h.pending_verdicts.size());
        if (checker_h.mismatches > REPORT_MAX)
            $display("%0d mismatches in total", checker_h.mismatches);

        if (checker_h.mismatches == 0 && checker_h.pending_verdicts.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
